// ===== hdl/artbl_pkg.sv =====
package artbl_pkg;

   // defaults for the top level parameters
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ADDR_WIDTH_DEF  = 48;
   localparam int ID_WIDTH_DEF    = 16;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   // operation codes carried in req_func
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_REMOVE   = 3'd1,
      FUNC_CONTAINS = 3'd2,
      FUNC_LOOKUP   = 3'd3,
      FUNC_CLEAR    = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_DUP  = 2'd2,
      STAT_NULL = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } dp_stat_type;

endpackage

// ===== hdl/artbl_ctrl.sv =====
module artbl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  artbl_pkg::dp_stat_type  stat,
   output artbl_pkg::dp_cmd_type   cmd
);
   import artbl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/artbl_dp.sv =====
module artbl_dp #(
   parameter int TABLE_DEPTH = artbl_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_WIDTH  = artbl_pkg::ADDR_WIDTH_DEF,
   parameter int ID_WIDTH    = artbl_pkg::ID_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  artbl_pkg::dp_cmd_type        cmd,
   output artbl_pkg::dp_stat_type       stat,
   input  logic [artbl_pkg::FUNC_W-1:0] req_func,
   input  logic [ID_WIDTH-1:0]          req_region_id,
   input  logic [ADDR_WIDTH-1:0]        req_region_base,
   input  logic [ADDR_WIDTH-1:0]        req_region_size,
   input  logic [ADDR_WIDTH-1:0]        req_query_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [ID_WIDTH-1:0]          rsp_match_id,
   output artbl_pkg::status_type        rsp_status
);
   import artbl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int END_W = ADDR_WIDTH + 1;

   // entry storage
   logic [ID_WIDTH-1:0]   mem_id   [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0] mem_base [TABLE_DEPTH];
   logic [END_W-1:0]      mem_end  [TABLE_DEPTH];

   // captured item
   func_type              op_func_ff;
   logic [ID_WIDTH-1:0]   op_id_ff;
   logic [ADDR_WIDTH-1:0] op_base_ff;
   logic [ADDR_WIDTH-1:0] op_size_ff;
   logic [ADDR_WIDTH-1:0] op_addr_ff;

   // scan state
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      wr_ptr_ff;
   logic                  rd_vld_ff;
   logic [ID_WIDTH-1:0]   rd_id_ff;
   logic [ADDR_WIDTH-1:0] rd_base_ff;
   logic [END_W-1:0]      rd_end_ff;
   logic                  id_hit_ff;
   logic                  addr_hit_ff;
   logic [ID_WIDTH-1:0]   addr_id_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [ID_WIDTH-1:0]   rsp_match_ff;
   status_type            rsp_status_ff;

   logic                  id_eq;
   logic                  addr_in;
   logic                  keep;
   logic [END_W-1:0]      ins_end;
   logic                  res_found;
   logic [ID_WIDTH-1:0]   res_match;
   status_type            res_status;
   logic [CNT_W-1:0]      count_in;
   logic                  ins_ok;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [ID_WIDTH-1:0]   mem_wid;
   logic [ADDR_WIDTH-1:0] mem_wbase;
   logic [END_W-1:0]      mem_wend;

   assign stat.scan_done = (rd_ptr_ff == count_ff);
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // capture the item on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_func_ff <= func_type'(req_func);
         op_id_ff   <= req_region_id;
         op_base_ff <= req_region_base;
         op_size_ff <= req_region_size;
         op_addr_ff <= req_query_addr;
      end
   end

   // compare stage on the entry read last cycle
   assign id_eq   = (rd_id_ff == op_id_ff);
   assign addr_in = (op_addr_ff >= rd_base_ff) && ({1'b0, op_addr_ff} < rd_end_ff);
   assign keep    = rd_vld_ff && (op_func_ff == FUNC_REMOVE) && !id_eq;

   // scan pointers and hit flags
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         id_hit_ff   <= 1'b0;
         addr_hit_ff <= 1'b0;
         addr_id_ff  <= '0;
      end else begin
         if (cmd.issue) begin
            rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
         end
         if (keep) begin
            wr_ptr_ff <= wr_ptr_ff + CNT_W'(1);
         end
         if (rd_vld_ff && id_eq) begin
            id_hit_ff <= 1'b1;
         end
         // first matching region wins
         if (rd_vld_ff && addr_in && !addr_hit_ff) begin
            addr_hit_ff <= 1'b1;
            addr_id_ff  <= rd_id_ff;
         end
      end
   end

   // read pipeline valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
      end
   end

   // memory read port
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_id_ff   <= mem_id[rd_ptr_ff[IDX_W-1:0]];
         rd_base_ff <= mem_base[rd_ptr_ff[IDX_W-1:0]];
         rd_end_ff  <= mem_end[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   // result, entry count and insert decision at commit
   assign ins_end = {1'b0, op_base_ff} + {1'b0, op_size_ff};

   always_comb begin
      res_found  = 1'b0;
      res_match  = '0;
      res_status = STAT_OK;
      count_in   = count_ff;
      ins_ok     = 1'b0;
      case (op_func_ff)
         FUNC_INSERT: begin
            if (op_id_ff == '0) begin
               res_status = STAT_NULL;
            end else if (id_hit_ff) begin
               res_status = STAT_DUP;
            end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
               res_status = STAT_FULL;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (op_id_ff == '0) begin
               res_status = STAT_NULL;
            end
            count_in = wr_ptr_ff;
         end
         FUNC_CONTAINS: begin
            if (op_id_ff == '0) begin
               res_status = STAT_NULL;
            end else begin
               res_found = id_hit_ff;
            end
         end
         FUNC_LOOKUP: begin
            res_found = addr_hit_ff;
            res_match = addr_id_ff;
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // memory write port: compaction on remove, append on insert
   always_comb begin
      mem_we    = keep;
      mem_waddr = wr_ptr_ff[IDX_W-1:0];
      mem_wid   = rd_id_ff;
      mem_wbase = rd_base_ff;
      mem_wend  = rd_end_ff;
      if (cmd.commit && ins_ok) begin
         mem_we    = 1'b1;
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wid   = op_id_ff;
         mem_wbase = op_base_ff;
         mem_wend  = ins_end;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_id[mem_waddr]   <= mem_wid;
         mem_base[mem_waddr] <= mem_wbase;
         mem_end[mem_waddr]  <= mem_wend;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_found_ff  <= res_found;
         rsp_match_ff  <= res_match;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_match_id = rsp_match_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== hdl/address_range_region_table_top.sv =====
// channel   direction  ports
// req       in         req_valid, req_stall, req_func, req_region_id,
//                      req_region_base, req_region_size, req_query_addr
// rsp       out        rsp_valid, rsp_stall, rsp_found, rsp_match_id, rsp_status
//
// one item at a time: ST_IDLE accepts it, ST_SCAN reads every stored entry in turn
// and then drains the read register, and ST_COMMIT writes the result once the output
// register is free; the single-port entry memory scan sets the length of an item.
// synchronous reset empties the table at once, no clearing pass.
// a stalled result sits in the output register while the next item is taken.
module address_range_region_table_top #(
   parameter int TABLE_DEPTH = artbl_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_WIDTH  = artbl_pkg::ADDR_WIDTH_DEF,
   parameter int ID_WIDTH    = artbl_pkg::ID_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [artbl_pkg::FUNC_W-1:0] req_func,
   input  logic [ID_WIDTH-1:0]          req_region_id,
   input  logic [ADDR_WIDTH-1:0]        req_region_base,
   input  logic [ADDR_WIDTH-1:0]        req_region_size,
   input  logic [ADDR_WIDTH-1:0]        req_query_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [ID_WIDTH-1:0]          rsp_match_id,
   output artbl_pkg::status_type        rsp_status
);
   import artbl_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   artbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage and compare logic
   artbl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_WIDTH  (ADDR_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_region_id   (req_region_id),
      .req_region_base (req_region_base),
      .req_region_size (req_region_size),
      .req_query_addr  (req_query_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_id    (rsp_match_id),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== tb/sv/region_table_checker.sv =====
module region_table_checker #(
   parameter int DEPTH = artbl_pkg::TABLE_DEPTH_DEF,
   parameter int AW    = artbl_pkg::ADDR_WIDTH_DEF,
   parameter int IW    = artbl_pkg::ID_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [artbl_pkg::FUNC_W-1:0] req_func,
   input  logic [IW-1:0]                req_region_id,
   input  logic [AW-1:0]                req_region_base,
   input  logic [AW-1:0]                req_region_size,
   input  logic [AW-1:0]                req_query_addr,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_found,
   input  logic [IW-1:0]                rsp_match_id,
   input  artbl_pkg::status_type        rsp_status,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import artbl_pkg::*;

   typedef struct packed {
      logic       found;
      logic [IW-1:0] match_id;
      status_type status;
   } region_reply_type;

   // replies owed by the block, oldest first
   region_reply_type replies_due[$];

   // shadow of the region slots; slots 0 .. slot_count-1 are live
   logic [IW-1:0] slot_id   [DEPTH];
   logic [AW-1:0] slot_base [DEPTH];
   logic [AW:0]   slot_end  [DEPTH];
   int            slot_count;

   function automatic logic id_stored(logic [IW-1:0] id);
      for (int i = 0; i < slot_count; i++)
         if (slot_id[i] == id)
            return 1'b1;
      return 1'b0;
   endfunction

   // apply one operation to the shadow slots and return the reply it owes
   function automatic region_reply_type apply_region_op(logic [FUNC_W-1:0] op,
                                                        logic [IW-1:0] id,
                                                        logic [AW-1:0] base,
                                                        logic [AW-1:0] size,
                                                        logic [AW-1:0] addr);
      region_reply_type r;
      int w;
      r.found    = 1'b0;
      r.match_id = '0;
      r.status   = STAT_OK;
      case (op)
         FUNC_INSERT: begin
            if (id == '0)
               r.status = STAT_NULL;
            else if (id_stored(id))
               r.status = STAT_DUP;
            else if (slot_count >= DEPTH)
               r.status = STAT_FULL;
            else begin
               slot_id[slot_count]   = id;
               slot_base[slot_count] = base;
               slot_end[slot_count]  = {1'b0, base} + {1'b0, size};
               slot_count++;
            end
         end
         FUNC_REMOVE: begin
            if (id == '0)
               r.status = STAT_NULL;
            else begin
               // squeeze out every match, keeping the order of the rest
               w = 0;
               for (int i = 0; i < slot_count; i++) begin
                  if (slot_id[i] != id) begin
                     slot_id[w]   = slot_id[i];
                     slot_base[w] = slot_base[i];
                     slot_end[w]  = slot_end[i];
                     w++;
                  end
               end
               slot_count = w;
            end
         end
         FUNC_CONTAINS: begin
            if (id == '0)
               r.status = STAT_NULL;
            else
               r.found = id_stored(id);
         end
         FUNC_LOOKUP: begin
            // oldest region holding the address wins
            for (int i = 0; i < slot_count; i++) begin
               if ({1'b0, addr} >= {1'b0, slot_base[i]} && {1'b0, addr} < slot_end[i]) begin
                  r.found    = 1'b1;
                  r.match_id = slot_id[i];
                  break;
               end
            end
         end
         FUNC_CLEAR: slot_count = 0;
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      region_reply_type due;
      region_reply_type want;
      if (reset) begin
         replies_due.delete();
         slot_count = 0;
         fail_count = 0;
      end else begin
         // predict on every accepted item
         if (req_valid && !req_stall) begin
            want = apply_region_op(req_func, req_region_id, req_region_base,
                                   req_region_size, req_query_addr);
            replies_due = {replies_due, want};
         end
         // compare every accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with none pending: found %0b id %h status %0d",
                           $realtime, rsp_found, rsp_match_id, rsp_status);
            end else begin
               due = replies_due.pop_front();
               if (rsp_found !== due.found || rsp_match_id !== due.match_id ||
                   rsp_status !== due.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: exp found %0b id %h st %0d, got found %0b id %h st %0d",
                              $realtime, due.found, due.match_id, due.status,
                              rsp_found, rsp_match_id, rsp_status);
               end
            end
         end
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== tb/sv/tb_address_range_region_table_top.sv =====
module tb_address_range_region_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import artbl_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int AW           = ADDR_WIDTH_DEF;
   localparam int IW           = ID_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 1310;
   localparam int QUIET_TAIL   = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [FUNC_W-1:0] req_func = FUNC_CLEAR;
   logic [IW-1:0]     req_region_id = '0;
   logic [AW-1:0]     req_region_base = '0;
   logic [AW-1:0]     req_region_size = '0;
   logic [AW-1:0]     req_query_addr = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [IW-1:0]     rsp_match_id;
   status_type        rsp_status;
   int                fail_count;
   int                outstanding;

   // no idling at all in the tail of the run
   logic quiet = 1'b0;
   logic calm_req = 1'b0;

   // recently inserted regions, used to aim lookups at their edges
   logic [AW-1:0] known_base[$];
   logic [AW-1:0] known_size[$];

   always #10 clock = ~clock;

   address_range_region_table_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_region_id   (req_region_id),
      .req_region_base (req_region_base),
      .req_region_size (req_region_size),
      .req_query_addr  (req_query_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_id    (rsp_match_id),
      .rsp_status      (rsp_status)
   );

   region_table_checker #(.DEPTH(DEPTH), .AW(AW), .IW(IW)) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_region_id   (req_region_id),
      .req_region_base (req_region_base),
      .req_region_size (req_region_size),
      .req_query_addr  (req_query_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_id    (rsp_match_id),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   function automatic logic [AW-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[AW-1:0];
   endfunction

   // mostly a small id pool so duplicates, hits and a full table are common
   function automatic logic [IW-1:0] pick_id();
      int p;
      p = $urandom_range(0, 99);
      if (p < 4)
         return '0;
      if (p < 84)
         return IW'($urandom_range(1, 24));
      if (p < 90)
         return '1;
      return IW'($urandom);
   endfunction

   function automatic logic [AW-1:0] pick_query();
      int p;
      int k;
      logic [AW-1:0] b;
      logic [AW-1:0] s;
      p = $urandom_range(0, 99);
      if (p < 60 && known_base.size() > 0) begin
         k = $urandom_range(0, known_base.size() - 1);
         b = known_base[k];
         s = known_size[k];
         case ($urandom_range(0, 3))
            0: return b;
            1: return b + s - 1'b1;
            2: return b + s;
            default: return b - 1'b1;
         endcase
      end
      if (p < 80)
         return AW'($urandom_range(0, 4700));
      if (p < 90)
         return rand_addr();
      if (p < 95)
         return '0;
      return '1;
   endfunction

   // present one item at the falling edge and hold it until accepted
   task automatic drive_op(input logic [FUNC_W-1:0] op, input logic [IW-1:0] id,
                           input logic [AW-1:0] base, input logic [AW-1:0] size,
                           input logic [AW-1:0] addr);
      if (!quiet && !calm_req && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_func        = op;
      req_region_id   = id;
      req_region_base = base;
      req_region_size = size;
      req_query_addr  = addr;
      req_valid       = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      if (op == FUNC_INSERT) begin
         known_base = {known_base, base};
         known_size = {known_size, size};
         if (known_base.size() > DEPTH) begin
            void'(known_base.pop_front());
            void'(known_size.pop_front());
         end
      end
   endtask

   task automatic random_op();
      int p;
      logic [FUNC_W-1:0] op;
      logic [AW-1:0] base;
      logic [AW-1:0] size;
      logic [AW-1:0] addr;
      p    = $urandom_range(0, 99);
      base = rand_addr();
      size = rand_addr();
      addr = pick_query();
      if (p < 35) begin
         op = FUNC_INSERT;
         case ($urandom_range(0, 3))
            0, 1: begin
               base = AW'($urandom_range(0, 4095));
               size = ($urandom_range(0, 7) == 0) ? '0 : AW'($urandom_range(1, 600));
            end
            2: size = rand_addr() >> $urandom_range(0, AW - 1);
            default: begin
               // near the top, so the end runs past the address width
               base = '1 - AW'($urandom_range(0, 4095));
               size = rand_addr() >> $urandom_range(0, 8);
            end
         endcase
      end else if (p < 47)
         op = FUNC_REMOVE;
      else if (p < 62)
         op = FUNC_CONTAINS;
      else if (p < 95)
         op = FUNC_LOOKUP;
      else if (p < 97)
         op = FUNC_CLEAR;
      else
         op = FUNC_W'(FUNC_CLEAR + $urandom_range(1, 3));
      drive_op(op, pick_id(), base, size, addr);
   endtask

   // result side back-pressure in random bursts
   initial begin
      int burst;
      int tick;
      logic calm;
      burst = 0;
      tick  = 0;
      calm  = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (quiet) begin
            burst = 0;
            rsp_stall = 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13) - 1;
            rsp_stall = 1'b1;
         end else
            rsp_stall = 1'b0;
      end
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("FAIL address_range_region_table_top");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table and null id handling
      drive_op(FUNC_LOOKUP, 16'h0001, '0, '0, '0);
      drive_op(FUNC_CONTAINS, '0, '1, '1, '1);
      drive_op(FUNC_REMOVE, '0, '0, '0, '0);
      drive_op(FUNC_INSERT, '0, 48'h10, 48'h10, '0);
      // small region, top region whose end needs the extra bit, empty region,
      // and an overlapping region behind the first
      drive_op(FUNC_INSERT, 16'h0001, '0, 48'h10, '0);
      drive_op(FUNC_INSERT, '1, '1, '1, '0);
      drive_op(FUNC_INSERT, 16'h0002, 48'h100, '0, '0);
      drive_op(FUNC_INSERT, 16'h0003, '0, 48'h100, '0);
      drive_op(FUNC_INSERT, 16'h0001, 48'h500, 48'h10, '0);
      drive_op(FUNC_LOOKUP, '0, '0, '0, 48'hf);
      drive_op(FUNC_LOOKUP, '0, '0, '0, 48'h10);
      drive_op(FUNC_LOOKUP, '0, '0, '0, 48'h100);
      drive_op(FUNC_LOOKUP, '0, '0, '0, '1);
      drive_op(FUNC_CONTAINS, '1, '0, '0, '0);
      drive_op(FUNC_CONTAINS, 16'h0005, '0, '0, '0);
      // absent id, then a real removal that closes the gap
      drive_op(FUNC_REMOVE, 16'h0009, '0, '0, '0);
      drive_op(FUNC_REMOVE, 16'h0001, '0, '0, '0);
      drive_op(FUNC_LOOKUP, '0, '0, '0, '0);
      // unused operation codes
      for (int k = 1; k <= 3; k++)
         drive_op(FUNC_W'(FUNC_CLEAR + k), 16'h0003, '1, '1, '0);
      // fill the table, then check the error order on a full table
      for (int k = 0; k < DEPTH - 3; k++)
         drive_op(FUNC_INSERT, IW'(16'h0100 + k), AW'($urandom_range(0, 4095)),
                  AW'($urandom_range(1, 600)), '0);
      drive_op(FUNC_INSERT, 16'h0200, '0, 48'h1, '0);
      drive_op(FUNC_INSERT, 16'h0002, '0, 48'h1, '0);
      drive_op(FUNC_INSERT, '0, '0, 48'h1, '0);
      drive_op(FUNC_CLEAR, '0, '0, '0, '0);
      drive_op(FUNC_LOOKUP, '0, '0, '0, '0);

      // random operations
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            calm_req = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS - QUIET_TAIL)
            quiet = 1'b1;
         random_op();
      end
      req_valid = 1'b0;

      // drain, then wait as long as two full-table items take, for anything stray
      while (outstanding != 0)
         @(negedge clock);
      repeat (2 * (DEPTH + 3)) @(negedge clock);
      if (fail_count == 0)
         $display("PASS address_range_region_table_top");
      else
         $display("FAIL address_range_region_table_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/artbl_pkg.sv
hdl/artbl_ctrl.sv
hdl/artbl_dp.sv
hdl/address_range_region_table_top.sv
tb/sv/region_table_checker.sv
tb/sv/tb_address_range_region_table_top.sv
